// ----- hw/rtl/rfu_pkg.sv -----
package rfu_pkg;

  localparam logic [7:0] HdrByte  = 8'hBB;
  localparam logic [7:0] TailByte = 8'h7E;

  localparam logic [7:0] AddrReset = 8'h02;
  localparam logic [7:0] CmdReset  = 8'h22;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_EXP_ADDR = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXP_CMD  = 1'd1;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_LENH = 3'd3;
  localparam logic [2:0] PH_LENL = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CSUM = 3'd6;
  localparam logic [2:0] PH_TAIL = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOHDR   = 3'd1;
  localparam logic [2:0] ST_EARLY   = 3'd2;
  localparam logic [2:0] ST_ADDRCMD = 3'd3;
  localparam logic [2:0] ST_CSUM    = 3'd4;
  localparam logic [2:0] ST_JUNK    = 3'd5;

  typedef struct packed {
    logic        is_frame_end;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [2:0]  frame_status;
    logic [15:0] frame_length;
  } rfu_res_t;

endpackage

// ----- hw/rtl/rfu_in_reg.sv -----
module rfu_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

// ----- hw/rtl/rfu_core.sv -----
module rfu_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      rx_byte_i,
  input  logic [7:0]      exp_addr_i,
  input  logic [7:0]      exp_cmd_i,
  output logic            res_valid_o,
  output rfu_pkg::rfu_res_t res_o
);
  import rfu_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  csum_q, csum_d;
  logic        junk_q, junk_d;
  logic [15:0] len_low;
  logic [15:0] cnt_inc;
  logic [7:0]  sum_add;

  assign len_low = {len_q[15:8], rx_byte_i};
  assign cnt_inc = cnt_q + 16'd1;
  assign sum_add = sum_q + rx_byte_i;

  always_comb begin
    phase_d     = phase_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    csum_d      = csum_q;
    junk_d      = junk_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (phase_q == PH_WAIT) begin
      if (rx_byte_i != HdrByte) begin
        res_valid_o        = 1'b1;
        res_o.is_frame_end = 1'b1;
        res_o.frame_status = ST_NOHDR;
        junk_d             = 1'b0;
      end else begin
        phase_d = PH_ADDR;
        addr_d  = '0;
        cmd_d   = '0;
        len_d   = '0;
        cnt_d   = '0;
        sum_d   = '0;
        csum_d  = '0;
        junk_d  = 1'b0;
      end
    end else if (phase_q == PH_TAIL) begin
      if (rx_byte_i != TailByte) begin
        junk_d = 1'b1;
      end else begin
        res_valid_o        = 1'b1;
        res_o.is_frame_end = 1'b1;
        res_o.frame_length = len_q;
        phase_d            = PH_WAIT;
        junk_d             = 1'b0;
        // Address or command mismatch outranks the checksum, which outranks junk.
        if (addr_q != exp_addr_i || cmd_q != exp_cmd_i) begin
          res_o.frame_status = ST_ADDRCMD;
        end else if (csum_q != sum_q) begin
          res_o.frame_status = ST_CSUM;
        end else if (junk_q) begin
          res_o.frame_status = ST_JUNK;
        end else begin
          res_o.frame_status = ST_OK;
        end
      end
    end else if (rx_byte_i == TailByte) begin
      res_valid_o        = 1'b1;
      res_o.is_frame_end = 1'b1;
      res_o.frame_status = ST_EARLY;
      res_o.frame_length = len_q;
      phase_d            = PH_WAIT;
      junk_d             = 1'b0;
    end else begin
      case (phase_q)
        PH_ADDR: begin
          addr_d  = rx_byte_i;
          sum_d   = sum_add;
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          sum_d   = sum_add;
          phase_d = PH_LENH;
        end
        PH_LENH: begin
          len_d   = {rx_byte_i, 8'h00};
          sum_d   = sum_add;
          phase_d = PH_LENL;
        end
        PH_LENL: begin
          len_d   = len_low;
          sum_d   = sum_add;
          cnt_d   = '0;
          phase_d = (len_low == 16'd0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          res_valid_o         = 1'b1;
          res_o.payload_byte  = rx_byte_i;
          res_o.payload_index = cnt_q;
          res_o.frame_length  = len_q;
          sum_d               = sum_add;
          cnt_d               = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CSUM;
          end
        end
        default: begin
          csum_d  = rx_byte_i;
          junk_d  = 1'b0;
          phase_d = PH_TAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      addr_q  <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      csum_q  <= '0;
      junk_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      csum_q  <= csum_d;
      junk_q  <= junk_d;
    end
  end

endmodule

// ----- hw/rtl/rfu_out_reg.sv -----
module rfu_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rfu_pkg::rfu_res_t res_i,
  output logic              can_load_o,
  output logic              valid_o,
  input  logic              ready_i,
  output rfu_pkg::rfu_res_t res_o
);
  import rfu_pkg::*;

  logic     valid_q, valid_d;
  rfu_res_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign res_o      = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hw/rtl/rfid_uart_frame_parser.sv -----
// Frame parser for a UHF RFID reader link: header 0xBB, address, command,
// 16-bit big-endian length, payload, checksum, tail 0x7E.
// The rx channel takes one UART byte per request. The res channel returns
// one request for each payload byte (is_frame_end low) and one status
// request at the end of each frame attempt (is_frame_end high); header,
// address, command, length and checksum bytes return nothing.
// The cfg channel writes the expected address (index 0) and command
// (index 1); it is always ready and the values are checked at the tail.
// A byte passes an input register and then the parser logic into an output
// register, from which its result shows on the res outputs. The parser state
// is updated by one byte in each cycle in which it steps, so one byte per
// cycle is sustained while the receiver keeps up.
// When the receiver stalls, the held result stays unchanged and the input
// register can still take one more byte before rx_ready_o drops.
// Reset empties both registers, returns the parser to waiting for a header
// and loads the expected address 0x02 and command 0x22.
module rfid_uart_frame_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic                        is_frame_end_o,
  output logic [7:0]                  payload_byte_o,
  output logic [15:0]                 payload_index_o,
  output logic [2:0]                  frame_status_o,
  output logic [15:0]                 frame_length_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rfu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import rfu_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_can_load;
  logic       step;
  logic       core_res_valid;
  rfu_res_t   core_res;
  rfu_res_t   out_res;
  logic [7:0] exp_addr_q;
  logic [7:0] exp_cmd_q;

  assign step        = in_valid && out_can_load;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= AddrReset;
      exp_cmd_q  <= CmdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EXP_ADDR: exp_addr_q <= cfg_data_i;
        CFG_EXP_CMD:  exp_cmd_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rfu_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_valid_i),
    .ready_o (rx_ready_o),
    .byte_i  (rx_byte_i),
    .take_i  (step),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  rfu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte),
    .exp_addr_i  (exp_addr_q),
    .exp_cmd_i   (exp_cmd_q),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  rfu_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && core_res_valid),
    .res_i      (core_res),
    .can_load_o (out_can_load),
    .valid_o    (res_valid_o),
    .ready_i    (res_ready_i),
    .res_o      (out_res)
  );

  assign is_frame_end_o  = out_res.is_frame_end;
  assign payload_byte_o  = out_res.payload_byte;
  assign payload_index_o = out_res.payload_index;
  assign frame_status_o  = out_res.frame_status;
  assign frame_length_o  = out_res.frame_length;

endmodule

// ----- hw/rtl/rfu_checker.sv -----
module rfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic        is_frame_end_o,
  input logic [7:0]  payload_byte_o,
  input logic [15:0] payload_index_o,
  input logic [2:0]  frame_status_o,
  input logic [15:0] frame_length_o
);
  import rfu_pkg::*;

  // A stalled result must not change or vanish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(is_frame_end_o)
      && $stable(payload_byte_o) && $stable(payload_index_o)
      && $stable(frame_status_o) && $stable(frame_length_o))
    else $error("stalled result changed");

  // Status results carry a defined code and no payload data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && is_frame_end_o |-> frame_status_o <= ST_JUNK
      && payload_byte_o == 8'h00 && payload_index_o == 16'h0000)
    else $error("malformed status result");

  // A payload byte lies inside the announced length and carries no status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !is_frame_end_o |-> frame_status_o == ST_OK
      && payload_index_o < frame_length_o)
    else $error("payload result out of frame");

  // A missing header never reports a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && is_frame_end_o && frame_status_o == ST_NOHDR
      |-> frame_length_o == 16'h0000)
    else $error("no-header status with length");

endmodule

bind rfid_uart_frame_parser rfu_checker u_rfu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_o     (res_valid_o),
  .res_ready_i     (res_ready_i),
  .is_frame_end_o  (is_frame_end_o),
  .payload_byte_o  (payload_byte_o),
  .payload_index_o (payload_index_o),
  .frame_status_o  (frame_status_o),
  .frame_length_o  (frame_length_o)
);

// ----- tb/rfid_uart_frame_parser_test.sv -----
`timescale 1ns / 100ps

module rfid_uart_frame_parser_test;
  import rfu_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic [2:0]  code;
    logic [15:0] len;
  } dir_row_t;

  // Status rows carry their result; the other rows go through the predictor.
  localparam dir_row_t DirRows [25] = '{
    '{8'h00, 1'b1, ST_NOHDR, 16'h0000},
    '{8'hFF, 1'b1, ST_NOHDR, 16'h0000},
    '{8'h7E, 1'b1, ST_NOHDR, 16'h0000},
    '{8'hBB, 1'b0, ST_OK, 16'h0000},
    '{8'h02, 1'b0, ST_OK, 16'h0000},
    '{8'h22, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, ST_OK, 16'h0000},
    '{8'h24, 1'b0, ST_OK, 16'h0000},
    '{8'h7E, 1'b1, ST_OK, 16'h0000},
    '{8'hBB, 1'b0, ST_OK, 16'h0000},
    '{8'h7E, 1'b1, ST_EARLY, 16'h0000},
    '{8'hBB, 1'b0, ST_OK, 16'h0000},
    '{8'h02, 1'b0, ST_OK, 16'h0000},
    '{8'h22, 1'b0, ST_OK, 16'h0000},
    '{8'h12, 1'b0, ST_OK, 16'h0000},
    '{8'h7E, 1'b1, ST_EARLY, 16'h1200},
    '{8'hBB, 1'b0, ST_OK, 16'h0000},
    '{8'h02, 1'b0, ST_OK, 16'h0000},
    '{8'h22, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, ST_OK, 16'h0000},
    '{8'h24, 1'b0, ST_OK, 16'h0000},
    '{8'h55, 1'b0, ST_OK, 16'h0000},
    '{8'h7E, 1'b1, ST_JUNK, 16'h0000}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                rx_valid_i = 1'b0;
  logic                rx_ready_o;
  logic [7:0]          rx_byte_i = 8'h00;
  logic                res_valid_o;
  logic                res_ready_i = 1'b0;
  logic                is_frame_end_o;
  logic [7:0]          payload_byte_o;
  logic [15:0]         payload_index_o;
  logic [2:0]          frame_status_o;
  logic [15:0]         frame_length_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_EXP_ADDR;
  logic [7:0]          cfg_data_i = 8'h00;

  rfid_uart_frame_parser dut (.*);

  // Parser state as the block should hold it.
  logic [2:0]  ph;
  logic [7:0]  seen_addr, seen_cmd, seen_csum, psum;
  logic [15:0] plen, pcount;
  logic        junk;
  logic [7:0]  want_addr, want_cmd;

  rfu_res_t    parse_results_q [$];
  rfu_res_t    want;
  int unsigned sent_bytes, mismatches, n_payload, n_status, n_ok, cycles;
  bit          gaps_on, stalls_on, hold_results;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic rfu_res_t end_status(input logic [2:0] code, input logic [15:0] len);
    ph = PH_WAIT;
    junk = 1'b0;
    return '{1'b1, 8'h00, 16'h0000, code, len};
  endfunction

  function automatic bit parse_rx_byte(input logic [7:0] b, output rfu_res_t res);
    res = '0;
    if (ph == PH_WAIT) begin
      if (b != HdrByte) begin
        res = end_status(ST_NOHDR, 16'h0000);
        return 1'b1;
      end
      ph = PH_ADDR;
      seen_addr = 8'h00;
      seen_cmd = 8'h00;
      plen = 16'h0000;
      pcount = 16'h0000;
      psum = 8'h00;
      seen_csum = 8'h00;
      junk = 1'b0;
      return 1'b0;
    end
    if (ph == PH_TAIL) begin
      if (b != TailByte) begin
        junk = 1'b1;
        return 1'b0;
      end
      if (seen_addr != want_addr || seen_cmd != want_cmd) res = end_status(ST_ADDRCMD, plen);
      else if (seen_csum != psum) res = end_status(ST_CSUM, plen);
      else if (junk) res = end_status(ST_JUNK, plen);
      else res = end_status(ST_OK, plen);
      return 1'b1;
    end
    if (b == TailByte) begin
      res = end_status(ST_EARLY, plen);
      return 1'b1;
    end
    case (ph)
      PH_ADDR: begin
        seen_addr = b;
        psum += b;
        ph = PH_CMD;
      end
      PH_CMD: begin
        seen_cmd = b;
        psum += b;
        ph = PH_LENH;
      end
      PH_LENH: begin
        plen = {b, 8'h00};
        psum += b;
        ph = PH_LENL;
      end
      PH_LENL: begin
        plen[7:0] = b;
        psum += b;
        pcount = 16'h0000;
        ph = (plen == 16'h0000) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        res = '{1'b0, b, pcount, ST_OK, plen};
        psum += b;
        pcount++;
        if (pcount >= plen) ph = PH_CSUM;
        return 1'b1;
      end
      default: begin
        seen_csum = b;
        junk = 1'b0;
        ph = PH_TAIL;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sent_bytes++;
  endtask

  task automatic feed(input logic [7:0] b);
    rfu_res_t r;
    send_byte(b);
    if (parse_rx_byte(b, r)) parse_results_q.push_back(r);
  endtask

  // Holds the rx side until every predicted result has come out.
  task automatic drain_results();
    rx_valid_i <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_ids(input logic [7:0] addr, input logic [7:0] cmd);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_EXP_ADDR;
    cfg_data_i <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    want_addr = addr;
    cfg_index_i <= CFG_EXP_CMD;
    cfg_data_i <= cmd;
    do @(posedge clk_i); while (!cfg_ready_o);
    want_cmd = cmd;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame();
    logic [7:0]  seq [$];
    logic [7:0]  sum, v;
    logic [15:0] len;
    int unsigned kind, n, cut;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      // Line noise between frames.
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
    end else begin
      seq.push_back(HdrByte);
      seq.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : want_addr);
      seq.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : want_cmd);
      if (kind <= 2) len = 16'($urandom);
      else if (kind == 3) len = 16'($urandom_range(41, 300));
      else if (kind <= 12) len = 16'($urandom_range(0, 6));
      else len = 16'($urandom_range(7, 24));
      seq.push_back(len[15:8]);
      seq.push_back(len[7:0]);
      n = (kind <= 2) ? $urandom_range(0, 3) : len;
      for (int i = 0; i < n; i++) begin
        v = 8'($urandom);
        if (v == TailByte && $urandom_range(0, 7) != 0) v = 8'h7D;
        seq.push_back(v);
      end
      if (kind <= 2) begin
        // Broken frame: the tail shows up somewhere before the checksum.
        cut = $urandom_range(1, seq.size());
        seq = seq[0:cut-1];
      end else begin
        sum = 8'h00;
        foreach (seq[i]) if (i > 0) sum += seq[i];
        if ($urandom_range(0, 7) == 0) sum ^= 8'($urandom_range(1, 255));
        seq.push_back(sum);
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            v = 8'($urandom);
            seq.push_back((v == TailByte) ? 8'h00 : v);
          end
        end
      end
      seq.push_back(TailByte);
    end
    foreach (seq[i]) feed(seq[i]);
  endtask

  task automatic run_frames(input int unsigned count);
    int unsigned stop_at;
    stop_at = sent_bytes + count;
    while (sent_bytes < stop_at) send_frame();
  endtask

  initial begin
    wait (rst_ni);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        res_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        res_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      res_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (parse_results_q.size() == 0) begin
        $error("result request with nothing expected (is_frame_end %0d)", is_frame_end_o);
        mismatches++;
      end else begin
        want = parse_results_q.pop_front();
        if (is_frame_end_o !== want.is_frame_end) begin
          $error("is_frame_end: expected %0d, got %0d", want.is_frame_end, is_frame_end_o);
          mismatches++;
        end
        if (payload_byte_o !== want.payload_byte) begin
          $error("payload_byte: expected %0d, got %0d", want.payload_byte, payload_byte_o);
          mismatches++;
        end
        if (payload_index_o !== want.payload_index) begin
          $error("payload_index: expected %0d, got %0d", want.payload_index, payload_index_o);
          mismatches++;
        end
        if (frame_status_o !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status, frame_status_o);
          mismatches++;
        end
        if (frame_length_o !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length, frame_length_o);
          mismatches++;
        end
        if (want.is_frame_end) n_status++;
        else n_payload++;
        if (want.is_frame_end && want.frame_status == ST_OK) n_ok++;
      end
    end
  end

  initial begin
    rfu_res_t r;
    ph = PH_WAIT;
    seen_addr = 8'h00;
    seen_cmd = 8'h00;
    seen_csum = 8'h00;
    psum = 8'h00;
    plen = 16'h0000;
    pcount = 16'h0000;
    junk = 1'b0;
    want_addr = AddrReset;
    want_cmd = CmdReset;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[k]) begin
      send_byte(DirRows[k].rx);
      // Typed rows still run the predictor so that its state stays in step.
      if (DirRows[k].typed) begin
        void'(parse_rx_byte(DirRows[k].rx, r));
        parse_results_q.push_back('{1'b1, 8'h00, 16'h0000, DirRows[k].code, DirRows[k].len});
      end else if (parse_rx_byte(DirRows[k].rx, r)) begin
        parse_results_q.push_back(r);
      end
    end

    // Each call ends on a frame boundary, so it runs a little past its count.
    run_frames(170);
    // The result side stalls for a long stretch while frames keep coming.
    hold_results = 1'b1;
    run_frames(170);
    drain_results();
    run_frames(170);

    drain_results();
    set_ids(8'h00, 8'h00);
    run_frames(180);
    drain_results();
    set_ids(8'hFF, 8'hFF);
    run_frames(180);
    drain_results();
    set_ids(8'($urandom), 8'($urandom));
    run_frames(180);
    drain_results();
    set_ids(AddrReset, CmdReset);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_frames(160);
    drain_results();
    repeat (6) @(posedge clk_i);

    $display("covered %0d rx bytes over four address/command settings", sent_bytes);
    $display("checked %0d payload bytes and %0d frame ends, %0d of them ok",
             n_payload, n_status, n_ok);
    if (mismatches == 0 && parse_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
